@@ hdl/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types and constants for the Chebyshev basis evaluator.
// ----------------------------------------------------------------------------
package cbe_pkg;

    // field widths
    localparam int ArgW     = 32;
    localparam int ValW     = 32;
    localparam int DerW     = 48;
    localparam int SlopeW   = 42;
    localparam int IdxW     = 5;
    localparam int ScaleW   = 31;
    localparam int MulW     = 33;
    localparam int ProdW    = 2 * MulW;
    localparam int SumW     = 76;
    localparam int TwW      = 46;
    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 32;

    // register indexes
    localparam logic [CfgAddrW-1:0] CFG_ORDER  = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_CENTER = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_SCALE  = 2'd2;

    // reset values
    localparam logic [IdxW-1:0]   ORDER_RST  = 5'd8;
    localparam logic [ScaleW-1:0] SCALE_RST  = 31'd65536;

    // 1.0 in Q2.30
    localparam logic signed [ValW-1:0] ONE_Q30 = 32'sh4000_0000;

    typedef struct packed {
        logic [IdxW-1:0]          order;
        logic signed [ArgW-1:0]   center;
        logic [ScaleW-1:0]        scale;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_FIN,
        ST_STEP,
        ST_REC_T,
        ST_REC_SLO,
        ST_REC_SHI,
        ST_REC_SUM,
        ST_DER_LO,
        ST_DER_HI,
        ST_DER_FIN,
        ST_EMIT
    } seq_state_t;

endpackage

@@ hdl/cbe_intf.sv @@
// ----------------------------------------------------------------------------
// cbe_intf
// Request channels of the Chebyshev basis evaluator: sample, result, config.
// ----------------------------------------------------------------------------
interface cbe_in_if;
    import cbe_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [ArgW-1:0] arg;

    modport source (output valid, output arg, input ready);
    modport sink   (input valid, input arg, output ready);
endinterface

interface cbe_out_if;
    import cbe_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [IdxW-1:0]        index;
    logic signed [ValW-1:0] value;
    logic signed [DerW-1:0] deriv;
    logic signed [ValW-1:0] arg_mapped;
    logic                   in_range;
    logic                   last;

    modport source (output valid, output index, output value, output deriv,
                    output arg_mapped, output in_range, output last,
                    input ready);
    modport sink   (input valid, input index, input value, input deriv,
                    input arg_mapped, input in_range, input last,
                    output ready);
endinterface

interface cbe_cfg_if;
    import cbe_pkg::*;

    logic                valid;
    logic                ready;
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ hdl/cbe_mul.sv @@
// ----------------------------------------------------------------------------
// cbe_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cbe_mul (
    input  logic                            clk,
    input  logic signed [cbe_pkg::MulW-1:0] a,
    input  logic signed [cbe_pkg::MulW-1:0] b,
    output logic signed [cbe_pkg::ProdW-1:0] prod
);
    import cbe_pkg::*;

    logic signed [ProdW-1:0] prod_reg;
    logic signed [ProdW-1:0] prod_next;

    // full-width product
    always_comb
    begin
        prod_next = ProdW'(a) * ProdW'(b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ hdl/cbe_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cbe_cfg_regs
// Configuration registers: order, interval centre and interval scale.
// ----------------------------------------------------------------------------
module cbe_cfg_regs #(
    parameter int MAX_ORDER = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    cbe_cfg_if.sink       cfg,
    output cbe_pkg::cfg_t regs
);
    import cbe_pkg::*;

    localparam logic [IdxW:0] MaxOrd = (IdxW+1)'(MAX_ORDER);

    logic [IdxW-1:0]        order_reg, order_next;
    logic signed [ArgW-1:0] center_reg, center_next;
    logic [ScaleW-1:0]      scale_reg, scale_next;

    assign cfg.ready = 1'b1;

    // write decode; unknown indexes are dropped
    always_comb
    begin
        order_next  = order_reg;
        center_next = center_reg;
        scale_next  = scale_reg;
        if (cfg.valid)
        begin
            priority if (cfg.addr == CFG_ORDER)
                order_next = cfg.data[IdxW-1:0];
            else if (cfg.addr == CFG_CENTER)
                center_next = signed'(cfg.data[ArgW-1:0]);
            else if (cfg.addr == CFG_SCALE)
                scale_next = cfg.data[ScaleW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= ORDER_RST;
            center_reg <= '0;
            scale_reg  <= SCALE_RST;
        end
        else
        begin
            order_reg  <= order_next;
            center_reg <= center_next;
            scale_reg  <= scale_next;
        end
    end

    // order limited to the supported maximum
    always_comb
    begin
        regs.order  = ({1'b0, order_reg} > MaxOrd) ? MaxOrd[IdxW-1:0] : order_reg;
        regs.center = center_reg;
        regs.scale  = scale_reg;
    end

endmodule

@@ hdl/cbe_seq.sv @@
// ----------------------------------------------------------------------------
// cbe_seq
// Sequencer and datapath: maps the sample, runs the recurrence over the
// shared multiplier and holds the result register.
// ----------------------------------------------------------------------------
module cbe_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cbe_pkg::cfg_t                    regs,
    cbe_in_if.sink                           sample,
    cbe_out_if.source                        result,
    output logic signed [cbe_pkg::MulW-1:0]  mul_a,
    output logic signed [cbe_pkg::MulW-1:0]  mul_b,
    input  logic signed [cbe_pkg::ProdW-1:0] prod
);
    import cbe_pkg::*;

    localparam int LoW = 30;
    localparam int SsW = SlopeW + 5;

    localparam logic signed [ProdW-1:0] MapLim  = ProdW'(64'sh1_0000_0000);
    localparam logic signed [ProdW-1:0] OneWide = ProdW'(ONE_Q30);
    localparam logic signed [SsW-1:0]   SMax    = SsW'(64'sh1FF_FFFF_FFFF);
    localparam logic signed [SsW-1:0]   SMin    = -SsW'(64'sh200_0000_0000);
    localparam logic signed [SumW-1:0]  DMax    = SumW'(64'sh7FFF_FFFF_FFFF);
    localparam logic signed [SumW-1:0]  DMin    = -SumW'(64'sh8000_0000_0000);
    localparam logic signed [SumW-1:0]  RndRec  = SumW'(64'sh1000_0000);
    localparam logic signed [SumW-1:0]  RndDer  = SumW'(64'sh8000);

    seq_state_t state_reg, state_next;
    logic [IdxW-1:0] k_reg, k_next;
    logic            out_valid_reg, out_valid_next;

    logic signed [MulW-1:0]   diff_reg, diff_next;
    logic signed [ValW-1:0]   x_reg, x_next;
    logic                     inside_reg, inside_next;
    logic signed [ValW-1:0]   vp_reg, vp_next, vp2_reg, vp2_next;
    logic signed [SlopeW-1:0] sp_reg, sp_next, sp2_reg, sp2_next;
    logic signed [ValW-1:0]   t_reg, t_next;
    logic signed [SlopeW-1:0] s_reg, s_next;
    logic signed [ProdW-1:0]  acc_reg, acc_next;
    logic signed [TwW-1:0]    tw_reg, tw_next;
    logic signed [DerW-1:0]   der_reg, der_next;

    logic [IdxW-1:0]        o_index_reg, o_index_next;
    logic signed [ValW-1:0] o_value_reg, o_value_next;
    logic signed [DerW-1:0] o_deriv_reg, o_deriv_next;
    logic signed [ValW-1:0] o_mapped_reg, o_mapped_next;
    logic                   o_inside_reg, o_inside_next;
    logic                   o_last_reg, o_last_next;

    logic signed [ProdW-1:0] map_rnd, rec_tq, rec_tt;
    logic signed [SumW-1:0]  wide_sum, der_full;
    logic signed [SsW-1:0]   s_sum;
    logic                    slot_free;

    assign sample.ready = (state_reg == ST_IDLE);
    assign slot_free    = !out_valid_reg || result.ready;

    // arithmetic around the shared multiplier
    always_comb
    begin
        map_rnd  = prod + ProdW'(2);
        rec_tq   = (prod + ProdW'(64'sh1000_0000)) >>> 29;
        rec_tt   = rec_tq - ProdW'(vp2_reg);
        if (state_reg == ST_DER_FIN)
            wide_sum = (SumW'(prod) <<< LoW) + SumW'(acc_reg) + RndDer;
        else
            wide_sum = (SumW'(prod) <<< LoW) + SumW'(acc_reg) + RndRec;
        der_full = wide_sum >>> 16;
        s_sum    = (SsW'(vp_reg) <<< 1) + SsW'(tw_reg) - SsW'(sp2_reg);
    end

    // next state, multiplier operands and datapath
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        diff_next      = diff_reg;
        x_next         = x_reg;
        inside_next    = inside_reg;
        vp_next        = vp_reg;
        vp2_next       = vp2_reg;
        sp_next        = sp_reg;
        sp2_next       = sp2_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        acc_next       = acc_reg;
        tw_next        = tw_reg;
        der_next       = der_reg;
        o_index_next   = o_index_reg;
        o_value_next   = o_value_reg;
        o_deriv_next   = o_deriv_reg;
        o_mapped_next  = o_mapped_reg;
        o_inside_next  = o_inside_reg;
        o_last_next    = o_last_reg;
        mul_a          = MulW'(x_reg);
        mul_b          = MulW'(vp_reg);

        if (result.valid && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    diff_next  = MulW'(sample.arg) - MulW'(regs.center);
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL:
            begin
                mul_a      = diff_reg;
                mul_b      = {2'b00, regs.scale};
                state_next = ST_MAP_FIN;
            end
            ST_MAP_FIN:
            begin
                // clamp onto [-1,1]; exactly one counts as inside
                if (prod > MapLim)
                begin
                    x_next      = ONE_Q30;
                    inside_next = 1'b0;
                end
                else if (prod < -MapLim)
                begin
                    x_next      = -ONE_Q30;
                    inside_next = 1'b0;
                end
                else
                begin
                    x_next      = map_rnd[ValW+1:2];
                    inside_next = 1'b1;
                end
                k_next     = '0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (k_reg == IdxW'(0))
                begin
                    t_next     = ONE_Q30;
                    s_next     = '0;
                    state_next = ST_DER_LO;
                end
                else if (k_reg == IdxW'(1))
                begin
                    t_next     = x_reg;
                    s_next     = SlopeW'(ONE_Q30);
                    state_next = ST_DER_LO;
                end
                else
                begin
                    state_next = ST_REC_T;
                end
            end
            ST_REC_T:
            begin
                // T(k) = round(2x*T(k-1)) - T(k-2), saturated to [-1,1]
                if (rec_tt > OneWide)
                    t_next = ONE_Q30;
                else if (rec_tt < -OneWide)
                    t_next = -ONE_Q30;
                else
                    t_next = rec_tt[ValW-1:0];
                mul_b      = {3'b000, sp_reg[LoW-1:0]};
                state_next = ST_REC_SLO;
            end
            ST_REC_SLO:
            begin
                acc_next   = prod;
                mul_b      = MulW'($signed(sp_reg[SlopeW-1:LoW]));
                state_next = ST_REC_SHI;
            end
            ST_REC_SHI:
            begin
                // round(2x*S(k-1)) from the two partial products
                tw_next    = wide_sum[TwW+28:29];
                state_next = ST_REC_SUM;
            end
            ST_REC_SUM:
            begin
                if (s_sum > SMax)
                    s_next = SMax[SlopeW-1:0];
                else if (s_sum < SMin)
                    s_next = SMin[SlopeW-1:0];
                else
                    s_next = s_sum[SlopeW-1:0];
                state_next = ST_DER_LO;
            end
            ST_DER_LO:
            begin
                mul_a      = {3'b000, s_reg[LoW-1:0]};
                mul_b      = {2'b00, regs.scale};
                state_next = ST_DER_HI;
            end
            ST_DER_HI:
            begin
                acc_next   = prod;
                mul_a      = MulW'($signed(s_reg[SlopeW-1:LoW]));
                mul_b      = {2'b00, regs.scale};
                state_next = ST_DER_FIN;
            end
            ST_DER_FIN:
            begin
                // slope times scale, Q.46 rounded to Q.30, saturated
                if (der_full > DMax)
                    der_next = DMax[DerW-1:0];
                else if (der_full < DMin)
                    der_next = DMin[DerW-1:0];
                else
                    der_next = der_full[DerW-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    o_index_next   = k_reg;
                    o_value_next   = t_reg;
                    o_deriv_next   = inside_reg ? der_reg : '0;
                    o_mapped_next  = x_reg;
                    o_inside_next  = inside_reg;
                    o_last_next    = (k_reg == regs.order);
                    vp2_next       = vp_reg;
                    vp_next        = t_reg;
                    sp2_next       = sp_reg;
                    sp_next        = s_reg;
                    if (k_reg == regs.order)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + IdxW'(1);
                        state_next = ST_STEP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        x_reg        <= x_next;
        inside_reg   <= inside_next;
        vp_reg       <= vp_next;
        vp2_reg      <= vp2_next;
        sp_reg       <= sp_next;
        sp2_reg      <= sp2_next;
        t_reg        <= t_next;
        s_reg        <= s_next;
        acc_reg      <= acc_next;
        tw_reg       <= tw_next;
        der_reg      <= der_next;
        o_index_reg  <= o_index_next;
        o_value_reg  <= o_value_next;
        o_deriv_reg  <= o_deriv_next;
        o_mapped_reg <= o_mapped_next;
        o_inside_reg <= o_inside_next;
        o_last_reg   <= o_last_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.index      = o_index_reg;
    assign result.value      = o_value_reg;
    assign result.deriv      = o_deriv_reg;
    assign result.arg_mapped = o_mapped_reg;
    assign result.in_range   = o_inside_reg;
    assign result.last       = o_last_reg;

endmodule

@@ hdl/chebyshev_basis_eval.sv @@
// Chebyshev basis evaluator: each sample request is mapped onto [-1,1] as
// (arg - centre) * scale, clamped, and then T0..T_order are produced one
// result per degree, each with the derivative with respect to arg. All
// arithmetic runs through one 33x33 multiplier with a registered product,
// driven by a small sequencer; the sample channel is not ready while a
// sample is in work. A sample is first mapped (accept, multiply, clamp);
// each result then runs the recurrence steps for T and its slope (skipped
// for degrees 0 and 1), scales the slope in two multiplier passes, and
// waits in the emit state until the result register is free. The result
// register lets the next sample be taken while the last result still
// waits.

// ----------------------------------------------------------------------------
// chebyshev_basis_eval
// Top level: configuration registers, sequencer and shared multiplier.
// ----------------------------------------------------------------------------
module chebyshev_basis_eval #(
    parameter int MAX_ORDER = 31
) (
    input  logic    clk,
    input  logic    rst_n,
    cbe_in_if.sink  sample,
    cbe_out_if.source result,
    cbe_cfg_if.sink cfg
);
    import cbe_pkg::*;

    cfg_t                   regs;
    logic signed [MulW-1:0]  mul_a;
    logic signed [MulW-1:0]  mul_b;
    logic signed [ProdW-1:0] prod;

    // configuration registers
    cbe_cfg_regs #(
        .MAX_ORDER (MAX_ORDER)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // shared multiplier
    cbe_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // sequencer and datapath
    cbe_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .regs   (regs),
        .sample (sample),
        .result (result),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .prod   (prod)
    );

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("sample taken while a sample is in work");

    a_clamped_no_deriv: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.in_range |-> result.deriv == '0)
        else $error("derivative not cleared for a clamped sample");

    a_t0_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.index == '0 |-> result.value == ONE_Q30)
        else $error("degree zero result is not one");

    a_last_at_order: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last |-> result.index == regs.order)
        else $error("last flag on a degree other than the order");

endmodule
